// File: rtl/max_mean_delay_queue_scheduler_macros.svh
// Assertion shorthands shared by the scheduler RTL.
`ifndef MAX_MEAN_DELAY_QUEUE_SCHEDULER_MACROS_SVH
`define MAX_MEAN_DELAY_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMDQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMDQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mmdq_pkg.sv
`timescale 1ns / 1ps
package mmdq_pkg;

    localparam int NUM_QUEUES = 3;
    localparam int QIDX_W     = 2;
    localparam int CAP_W      = 8;
    localparam int EVT_W      = 32;
    localparam int LOSS_W     = 32;

    localparam logic ACT_ARRIVAL  = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    localparam logic [QIDX_W-1:0] CFG_CAP_Q0 = 2'd0;
    localparam logic [QIDX_W-1:0] CFG_CAP_Q1 = 2'd1;
    localparam logic [QIDX_W-1:0] CFG_CAP_Q2 = 2'd2;

    typedef struct packed {
        logic              action;
        logic [QIDX_W-1:0] queue_index;
        logic [EVT_W-1:0]  event_time;
    } t_in_item;

    typedef struct packed {
        logic              dropped;
        logic              served_valid;
        logic [QIDX_W-1:0] served_queue;
        logic [EVT_W-1:0]  served_arrival_time;
        logic              server_busy;
        logic [CAP_W-1:0]  length_queue0;
        logic [CAP_W-1:0]  length_queue1;
        logic [CAP_W-1:0]  length_queue2;
        logic [LOSS_W-1:0] losses_queue0;
        logic [LOSS_W-1:0] losses_queue1;
        logic [LOSS_W-1:0] losses_queue2;
    } t_out_item;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic done;
        logic less;
    } t_cmp_res;

endpackage

// File: rtl/mmdq_tstore.sv
`timescale 1ns / 1ps
module mmdq_tstore import mmdq_pkg::*; #(
    parameter int ENTRIES = 384,
    parameter int AW      = 9,
    parameter int DW      = 32
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [ENTRIES];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mmdq_mean_cmp.sv
`timescale 1ns / 1ps
module mmdq_mean_cmp import mmdq_pkg::*; #(
    parameter int SUM_W = 39
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_sum_a,
    input  logic [CAP_W-1:0] i_cnt_a,
    input  logic [SUM_W-1:0] i_sum_b,
    input  logic [CAP_W-1:0] i_cnt_b,
    output t_cmp_res         o_res
);

    localparam int PW = SUM_W + CAP_W;

    typedef enum logic [1:0] {P_IDLE, P_MB, P_CMP} t_phase;

    t_phase        r_ph;
    t_cmp_res      r_res;
    logic [PW-1:0] r_prod_a;
    logic [PW-1:0] r_prod_b;
    logic [PW-1:0] w_prod;

    // One multiplier serves both cross products: S_a*n_b first, then S_b*n_a.
    always_comb begin
        if (r_ph == P_IDLE) begin
            w_prod = PW'(i_sum_a) * PW'(i_cnt_b);
        end else begin
            w_prod = PW'(i_sum_b) * PW'(i_cnt_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= P_IDLE;
            r_res <= '0;
        end else begin
            r_res.done <= 1'b0;
            unique case (r_ph)
                P_IDLE: begin
                    if (i_start) begin
                        r_prod_a <= w_prod;
                        r_ph     <= P_MB;
                    end
                end
                P_MB: begin
                    r_prod_b <= w_prod;
                    r_ph     <= P_CMP;
                end
                P_CMP: begin
                    r_res.done <= 1'b1;
                    r_res.less <= (r_prod_a < r_prod_b);
                    r_ph       <= P_IDLE;
                end
                default: r_ph <= P_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/max_mean_delay_queue_scheduler.sv
`timescale 1ns / 1ps
// Each request is applied and reported; while the server is idle the queues are also scanned
// (at most two mean comparisons) and the head of the winning queue is read and served.
// The sequencer and the shared multiplier work on one request at a time, so no new request
// is taken while busy is high. The receiver cannot stall the result strobe.
// Reset (synchronous, active low) empties all queues, clears loss counters and the
// server, and sets every capacity to 20; the timestamp memory itself is not cleared.
module max_mean_delay_queue_scheduler import mmdq_pkg::*; #(
    parameter int QUEUE_DEPTH = 128,
    parameter int TIME_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_strobe,
    output t_out_item         o_result,
    input  logic              i_cfg_we,
    input  logic [QIDX_W-1:0] i_cfg_idx,
    input  logic [CAP_W-1:0]  i_cfg_data
);

`include "max_mean_delay_queue_scheduler_macros.svh"

    localparam int SW       = (TIME_BITS < EVT_W) ? TIME_BITS : EVT_W;
    localparam int PTRW     = $clog2(QUEUE_DEPTH);
    localparam int SUMW     = SW + PTRW;
    localparam int ENTRIES  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW       = $clog2(ENTRIES);
    localparam int CAP_LIM  = (QUEUE_DEPTH < 255) ? QUEUE_DEPTH : 255;
    localparam logic [QIDX_W-1:0] LAST_Q = QIDX_W'(NUM_QUEUES - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_APPLY, S_SEL, S_CMPW, S_READ, S_FIN, S_OUT
    } t_state;

    t_state            r_state;
    t_in_item          r_item;
    t_out_item         r_res;
    logic              r_strobe;
    logic              r_srv;
    logic              r_drop;
    logic              r_serve;
    logic              r_best_v;
    logic [QIDX_W-1:0] r_best;
    logic [QIDX_W-1:0] r_idx;
    logic [CAP_W-1:0]  r_cap  [NUM_QUEUES];
    logic [CAP_W-1:0]  r_cnt  [NUM_QUEUES];
    logic [PTRW-1:0]   r_head [NUM_QUEUES];
    logic [SUMW-1:0]   r_sum  [NUM_QUEUES];
    logic [LOSS_W-1:0] r_loss [NUM_QUEUES];

    logic              w_q_ok;
    logic [QIDX_W-1:0] w_q;
    logic              w_full;
    logic [SW-1:0]     w_t;
    logic [PTRW:0]     w_tail_sum;
    logic [PTRW-1:0]   w_tail;
    logic [PTRW-1:0]   w_head_inc;
    logic              w_take;
    logic              w_cmp;
    t_mem_ctl          w_mem_ctl;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [SW-1:0]     w_rd;
    t_cmp_res          w_cmp_res;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_cap[i] <= CAP_W'(20);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAP_Q0: r_cap[0] <= i_cfg_data;
                CFG_CAP_Q1: r_cap[1] <= i_cfg_data;
                CFG_CAP_Q2: r_cap[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_q_ok = (r_item.queue_index < QIDX_W'(NUM_QUEUES));
    assign w_q    = w_q_ok ? r_item.queue_index : '0;
    assign w_t    = r_item.event_time[SW-1:0];
    assign w_full = (r_cnt[w_q] >= r_cap[w_q]) || (r_cnt[w_q] >= CAP_W'(CAP_LIM));

    // The tail is only formed for a queue below its limit, so the count fits PTRW bits.
    assign w_tail_sum = {1'b0, r_head[w_q]} + {1'b0, PTRW'(r_cnt[w_q])};
    assign w_tail = (w_tail_sum >= (PTRW+1)'(QUEUE_DEPTH))
                  ? PTRW'(w_tail_sum - (PTRW+1)'(QUEUE_DEPTH))
                  : PTRW'(w_tail_sum);
    assign w_head_inc = (r_head[r_best] == PTRW'(QUEUE_DEPTH - 1))
                      ? '0 : r_head[r_best] + PTRW'(1);

    assign w_take = (r_cnt[r_idx] != '0) && !r_best_v;
    assign w_cmp  = (r_cnt[r_idx] != '0) && r_best_v;

    // Writes happen only in the apply state and reads only in the read state, so the
    // sequencer itself keeps accesses to one entry from overlapping.
    assign w_mem_ctl.we = (r_state == S_APPLY) && (r_item.action == ACT_ARRIVAL)
                        && w_q_ok && !w_full;
    assign w_mem_ctl.re = (r_state == S_READ);
    assign w_waddr = AW'(w_q) * AW'(QUEUE_DEPTH) + AW'(w_tail);
    assign w_raddr = AW'(r_best) * AW'(QUEUE_DEPTH) + AW'(r_head[r_best]);

    mmdq_tstore #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .DW      (SW)
    ) u_tstore (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_t),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    mmdq_mean_cmp #(
        .SUM_W (SUMW)
    ) u_mean_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_SEL) && !r_srv && w_cmp),
        .i_sum_a (r_sum[r_idx]),
        .i_cnt_a (r_cnt[r_idx]),
        .i_sum_b (r_sum[r_best]),
        .i_cnt_b (r_cnt[r_best]),
        .o_res   (w_cmp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_srv    <= 1'b0;
            r_drop   <= 1'b0;
            r_serve  <= 1'b0;
            r_best_v <= 1'b0;
            r_best   <= '0;
            r_idx    <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
                r_sum[i]  <= '0;
                r_loss[i] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item  <= i_item;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_drop   <= 1'b0;
                    r_serve  <= 1'b0;
                    r_best_v <= 1'b0;
                    r_best   <= '0;
                    r_idx    <= '0;
                    if (r_item.action == ACT_COMPLETE) begin
                        r_srv <= 1'b0;
                    end else if (w_q_ok) begin
                        if (w_full) begin
                            r_drop <= 1'b1;
                            if (r_loss[w_q] != '1) begin
                                r_loss[w_q] <= r_loss[w_q] + LOSS_W'(1);
                            end
                        end else begin
                            r_cnt[w_q] <= r_cnt[w_q] + CAP_W'(1);
                            r_sum[w_q] <= r_sum[w_q] + SUMW'(w_t);
                        end
                    end
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    if (r_srv) begin
                        r_state <= S_OUT;
                    end else if (w_cmp) begin
                        r_state <= S_CMPW;
                    end else begin
                        if (w_take) begin
                            r_best   <= r_idx;
                            r_best_v <= 1'b1;
                        end
                        if (r_idx == LAST_Q) begin
                            r_state <= (r_best_v || w_take) ? S_READ : S_OUT;
                        end else begin
                            r_idx <= r_idx + QIDX_W'(1);
                        end
                    end
                end
                S_CMPW: begin
                    if (w_cmp_res.done) begin
                        // Strictly smaller mean arrival wins, so ties keep the lower index.
                        if (w_cmp_res.less) begin
                            r_best <= r_idx;
                        end
                        if (r_idx == LAST_Q) begin
                            r_state <= S_READ;
                        end else begin
                            r_idx   <= r_idx + QIDX_W'(1);
                            r_state <= S_SEL;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_serve        <= 1'b1;
                    r_srv          <= 1'b1;
                    r_sum[r_best]  <= r_sum[r_best] - SUMW'(w_rd);
                    r_head[r_best] <= w_head_inc;
                    r_cnt[r_best]  <= r_cnt[r_best] - CAP_W'(1);
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    r_strobe                  <= 1'b1;
                    r_res.dropped             <= r_drop;
                    r_res.served_valid        <= r_serve;
                    r_res.served_queue        <= r_serve ? r_best : '0;
                    r_res.served_arrival_time <= r_serve ? EVT_W'(w_rd) : '0;
                    r_res.server_busy         <= r_srv;
                    r_res.length_queue0       <= r_cnt[0];
                    r_res.length_queue1       <= r_cnt[1];
                    r_res.length_queue2       <= r_cnt[2];
                    r_res.losses_queue0       <= r_loss[0];
                    r_res.losses_queue1       <= r_loss[1];
                    r_res.losses_queue2       <= r_loss[2];
                    r_state                   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `MMDQ_ASSERT_NXT(a_out_strobe, i_clk, i_rst_n,
                     r_state == S_OUT, o_strobe, "result not strobed")
    `MMDQ_ASSERT_NXT(a_accept_apply, i_clk, i_rst_n,
                     start && !busy, r_state == S_APPLY, "request lost")
    `MMDQ_ASSERT_IMP(a_served_busy, i_clk, i_rst_n,
                     o_strobe && o_result.served_valid, o_result.server_busy,
                     "served while idle")
    `MMDQ_ASSERT_IMP(a_cmp_owner, i_clk, i_rst_n,
                     w_cmp_res.done, r_state == S_CMPW, "stray compare result")
    `MMDQ_ASSERT_IMP(a_cnt_limit, i_clk, i_rst_n,
                     1'b1, r_cnt[0] <= CAP_W'(CAP_LIM), "queue 0 over depth")

endmodule

// File: bench/scheduler_checker.sv
`timescale 1ns / 1ps
module scheduler_checker import mmdq_pkg::*; #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_in_item          i_item,
    input  logic              i_strobe,
    input  t_out_item         i_result,
    input  logic              i_cfg_we,
    input  logic [QIDX_W-1:0] i_cfg_idx,
    input  logic [CAP_W-1:0]  i_cfg_data,
    output int                o_reports_due,
    output int                o_mismatches
);

    logic [EVT_W-1:0]  stamp_ring [NUM_QUEUES][QUEUE_DEPTH];
    int                ring_head  [NUM_QUEUES];
    int                occupancy  [NUM_QUEUES];
    logic [63:0]       stamp_sum  [NUM_QUEUES];
    logic [LOSS_W-1:0] drop_total [NUM_QUEUES];
    logic [CAP_W-1:0]  capacity   [NUM_QUEUES];
    logic              server_busy;

    t_out_item expected_reports [$];
    int        outstanding = 0;
    int        mismatch_count = 0;

    assign o_reports_due = outstanding;
    assign o_mismatches  = mismatch_count;

    // Applies one request to the shadow state and returns the report it should produce.
    function automatic t_out_item schedule_request(input t_in_item req);
        t_out_item        res;
        int               q;
        int               limit;
        int               pick;
        logic [63:0]      lhs;
        logic [63:0]      rhs;
        logic [EVT_W-1:0] served;
        res = '0;
        q = req.queue_index;
        if (req.action == ACT_ARRIVAL) begin
            if (q < NUM_QUEUES) begin
                limit = (capacity[q] > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity[q];
                if (occupancy[q] < limit) begin
                    stamp_ring[q][(ring_head[q] + occupancy[q]) % QUEUE_DEPTH] = req.event_time;
                    occupancy[q]++;
                    stamp_sum[q] += 64'(req.event_time);
                end else begin
                    res.dropped = 1'b1;
                    if (drop_total[q] != '1) begin
                        drop_total[q]++;
                    end
                end
            end
        end else begin
            server_busy = 1'b0;
        end

        if (!server_busy) begin
            pick = -1;
            // Smallest mean arrival time wins; compare S_i*n_j against S_j*n_i exactly.
            for (int i = 0; i < NUM_QUEUES; i++) begin
                if (occupancy[i] != 0) begin
                    if (pick < 0) begin
                        pick = i;
                    end else begin
                        lhs = stamp_sum[i] * 64'(occupancy[pick]);
                        rhs = stamp_sum[pick] * 64'(occupancy[i]);
                        if (lhs < rhs) begin
                            pick = i;
                        end
                    end
                end
            end
            if (pick >= 0) begin
                served = stamp_ring[pick][ring_head[pick]];
                stamp_sum[pick] -= 64'(served);
                ring_head[pick] = (ring_head[pick] + 1) % QUEUE_DEPTH;
                occupancy[pick]--;
                server_busy = 1'b1;
                res.served_valid = 1'b1;
                res.served_queue = QIDX_W'(pick);
                res.served_arrival_time = served;
            end
        end

        res.server_busy   = server_busy;
        res.length_queue0 = CAP_W'(occupancy[0]);
        res.length_queue1 = CAP_W'(occupancy[1]);
        res.length_queue2 = CAP_W'(occupancy[2]);
        res.losses_queue0 = drop_total[0];
        res.losses_queue1 = drop_total[1];
        res.losses_queue2 = drop_total[2];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                ring_head[i]  = 0;
                occupancy[i]  = 0;
                stamp_sum[i]  = '0;
                drop_total[i] = '0;
                capacity[i]   = CAP_W'(20);
            end
            server_busy = 1'b0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx < NUM_QUEUES) begin
                capacity[i_cfg_idx] = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                expected_reports.push_back(schedule_request(i_item));
            end
            if (i_strobe) begin
                if (expected_reports.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("dropped", want.dropped, i_result.dropped);
                    check_field("served_valid", want.served_valid, i_result.served_valid);
                    check_field("served_queue", want.served_queue, i_result.served_queue);
                    check_field("served_arrival_time", want.served_arrival_time,
                                i_result.served_arrival_time);
                    check_field("server_busy", want.server_busy, i_result.server_busy);
                    check_field("length_queue0", want.length_queue0, i_result.length_queue0);
                    check_field("length_queue1", want.length_queue1, i_result.length_queue1);
                    check_field("length_queue2", want.length_queue2, i_result.length_queue2);
                    check_field("losses_queue0", want.losses_queue0, i_result.losses_queue0);
                    check_field("losses_queue1", want.losses_queue1, i_result.losses_queue1);
                    check_field("losses_queue2", want.losses_queue2, i_result.losses_queue2);
                end
            end
        end
        // Registered so the stimulus side always reads the count as of the previous edge.
        outstanding <= expected_reports.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mmdq_pkg::*;

    localparam logic [QIDX_W-1:0] NO_QUEUE     = 2'd3;
    localparam logic [QIDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [QIDX_W-1:0] CAP_REGS [NUM_QUEUES] = '{CFG_CAP_Q0, CFG_CAP_Q1, CFG_CAP_Q2};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in_item          i_item = '0;
    logic              o_strobe;
    t_out_item         o_result;
    logic              i_cfg_we = 1'b0;
    logic [QIDX_W-1:0] i_cfg_idx = '0;
    logic [CAP_W-1:0]  i_cfg_data = '0;

    int                reports_due;
    int                mismatch_total;
    logic [EVT_W-1:0]  now_ticks = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    max_mean_delay_queue_scheduler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    scheduler_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_strobe      (o_strobe),
        .i_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_reports_due (reports_due),
        .o_mismatches  (mismatch_total)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic t_in_item make_request(input logic act, input logic [QIDX_W-1:0] q,
                                              input logic [EVT_W-1:0] stamp);
        t_in_item req;
        req.action      = act;
        req.queue_index = q;
        req.event_time  = stamp;
        return req;
    endfunction

    // Returns at the edge that took the request, with start still high.
    task automatic send_request(input t_in_item req, input int gap);
        logic [63:0] noise;
        if (gap > 0) begin
            noise = {$urandom, $urandom};
            start  <= 1'b0;
            i_item <= noise[$bits(t_in_item)-1:0];
            repeat (gap) @(posedge i_clk);
        end
        i_item <= req;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic run_traffic(input int count, input int arrival_pct, input bit steady);
        t_in_item req;
        int       roll;
        for (int n = 0; n < count; n++) begin
            // Mostly small forward steps with many repeats, now and then an arbitrary jump.
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                now_ticks = $urandom;
            end else if (roll >= 40) begin
                now_ticks += $urandom_range(1, 1000);
            end
            req.event_time = now_ticks;
            req.action = ($urandom_range(0, 99) < arrival_pct) ? ACT_ARRIVAL : ACT_COMPLETE;
            if (req.action == ACT_COMPLETE) begin
                req.queue_index = QIDX_W'($urandom_range(0, 3));
            end else if ($urandom_range(0, 19) == 0) begin
                req.queue_index = NO_QUEUE;
            end else begin
                req.queue_index = QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
            end
            send_request(req, steady ? 0 : pick_gap());
        end
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (reports_due != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic program_capacities(input logic [CAP_W-1:0] c0, input logic [CAP_W-1:0] c1,
                                      input logic [CAP_W-1:0] c2, input bit poke_unmapped);
        logic [CAP_W-1:0] values [NUM_QUEUES];
        values = '{c0, c1, c2};
        if (poke_unmapped) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_UNMAPPED;
            i_cfg_data <= CAP_W'($urandom);
            @(posedge i_clk);
        end
        for (int r = 0; r < NUM_QUEUES; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CAP_REGS[r];
            i_cfg_data <= values[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_item script [$];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle completions, the missing fourth queue, extreme stamps, backward time, ties.
        script.push_back(make_request(ACT_COMPLETE, 0, 32'd0));
        script.push_back(make_request(ACT_ARRIVAL, NO_QUEUE, 32'd5));
        script.push_back(make_request(ACT_ARRIVAL, 0, 32'd0));
        script.push_back(make_request(ACT_ARRIVAL, 1, 32'hFFFF_FFFF));
        script.push_back(make_request(ACT_ARRIVAL, 2, 32'hFFFF_FFFF));
        script.push_back(make_request(ACT_ARRIVAL, 2, 32'd0));
        script.push_back(make_request(ACT_ARRIVAL, NO_QUEUE, 32'hFFFF_FFFF));
        script.push_back(make_request(ACT_COMPLETE, 3, 32'hFFFF_FFFF));
        script.push_back(make_request(ACT_COMPLETE, 1, 32'd5));
        script.push_back(make_request(ACT_COMPLETE, 2, 32'd5));
        script.push_back(make_request(ACT_COMPLETE, 0, 32'd6));
        script.push_back(make_request(ACT_COMPLETE, 0, 32'd6));
        script.push_back(make_request(ACT_ARRIVAL, 0, 32'd7));
        script.push_back(make_request(ACT_ARRIVAL, 1, 32'd7));
        script.push_back(make_request(ACT_ARRIVAL, 2, 32'd7));
        script.push_back(make_request(ACT_ARRIVAL, 0, 32'd7));
        script.push_back(make_request(ACT_COMPLETE, 0, 32'd8));
        script.push_back(make_request(ACT_COMPLETE, 0, 32'd8));
        script.push_back(make_request(ACT_COMPLETE, 0, 32'd9));
        script.push_back(make_request(ACT_COMPLETE, 0, 32'd9));
        foreach (script[k]) begin
            send_request(script[k], pick_gap());
        end

        // Capacities still at their reset value here.
        now_ticks = 32'd9;
        run_traffic(250, 75, 1'b0);
        wait_for_results();

        // A closed queue, one asking for more than the ring holds, and a single slot.
        program_capacities(8'd0, 8'd255, 8'd1, 1'b1);
        script.delete();
        script.push_back(make_request(ACT_ARRIVAL, 0, now_ticks));
        script.push_back(make_request(ACT_ARRIVAL, 1, now_ticks));
        script.push_back(make_request(ACT_ARRIVAL, 2, now_ticks));
        script.push_back(make_request(ACT_ARRIVAL, 2, now_ticks));
        foreach (script[k]) begin
            send_request(script[k], pick_gap());
        end
        run_traffic(250, 80, 1'b0);
        wait_for_results();

        // Arrival heavy and back to back, so the queues run up toward their ring depth.
        program_capacities(8'd128, 8'd128, 8'd128, 1'b0);
        run_traffic(500, 90, 1'b1);
        wait_for_results();

        program_capacities(8'd255, 8'd200, 8'd129, 1'b0);
        run_traffic(300, 40, 1'b0);
        wait_for_results();

        program_capacities(8'd1, 8'd2, 8'd3, 1'b0);
        run_traffic(200, 55, 1'b0);
        wait_for_results();

        repeat (3) begin
            program_capacities(CAP_W'($urandom_range(0, 255)), CAP_W'($urandom_range(0, 255)),
                               CAP_W'($urandom_range(0, 255)), 1'b0);
            run_traffic(150, 55, 1'b0);
            wait_for_results();
        end

        if (reports_due != 0) begin
            $error("%0d results never arrived", reports_due);
        end
        if (mismatch_total == 0 && reports_due == 0) begin
            $display("[max_mean_delay_queue_scheduler] OK");
        end else begin
            $display("[max_mean_delay_queue_scheduler] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[max_mean_delay_queue_scheduler] ERROR");
        $finish;
    end

endmodule
